FILE: hdl/assert_macros.svh
// Assertion macros shared by the haversine distance RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant checked on every clock edge outside reset
`define HVD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next
`define HVD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: hdl/hvd_pkg.sv
// Types, constants and tables for the haversine distance pipeline
`timescale 1ns / 1ps
package hvd_pkg;

  localparam int CORDIC_STAGES_DEF = 20;
  localparam int ATAN_LEN          = 32;
  localparam int LANES             = 4;

  localparam int LAT_W   = 24;
  localparam int LON_W   = 25;
  localparam int DIST_W  = 23;
  localparam int ANG_W   = 34;   // CORDIC datapath, signed
  localparam int Q_W     = 31;   // Q30 values in [0, 1.0]
  localparam int MAG_W   = 25;   // magnitude of a clamped angle or difference
  localparam int RECIP_W = 27;
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam int QUO_W   = PROD_W - 32;
  localparam int RAD_W   = 61;   // square root radicand, up to 2^60
  localparam int SQ_W    = 62;
  localparam int ROOT_STEPS = 31;
  localparam int BAM_W   = 33;
  localparam int FULL_SHIFT = 13;
  localparam int HALF_SHIFT = 12;
  localparam int DIV_K   = 45;

  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic [Q_W-1:0]          q30_t;
  typedef logic [MAG_W-1:0]        mag_t;

  localparam logic signed [LAT_W-1:0] LAT_MAX = 24'sd5898240;
  localparam logic signed [LON_W-1:0] LON_MAX = 25'sd11796480;
  localparam q30_t                Q30_ONE  = 31'h4000_0000;
  localparam logic [2*Q_W-1:0]    Q30_HALF = 62'h2000_0000;
  localparam ang_t                CORDIC_GAIN = 34'sd652032874;
  localparam logic [RECIP_W-1:0]  RECIP45  = 27'd95443718;   // ceil(2^32 / 45)
  localparam logic [BAM_W-1:0]    BAM_QUARTER = 33'h0_4000_0000;
  localparam logic [BAM_W-1:0]    BAM_HALF    = 33'h0_8000_0000;
  localparam logic [RAD_W-1:0]    RAD_ONE     = 61'h1000_0000_0000_0000;
  localparam logic [32:0]         DIST_MUL = 33'd5246834913;
  localparam logic [DIST_W-1:0]   DIST_MAX = 23'd5124096;

  typedef logic [31:0] atan_tab_t [ATAN_LEN];
  localparam atan_tab_t ATAN_TAB = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // floor((rem * scale + 22) / 45) for the remainder of a division by 45
  typedef logic [13:0] frac_tab_t [64];
  function automatic frac_tab_t mk_frac_tab(input int scale);
    frac_tab_t t;
    for (int i = 0; i < 64; i++) t[i] = 14'((i * scale + 22) / 45);
    return t;
  endfunction

  localparam frac_tab_t FRAC_FULL = mk_frac_tab(8192);
  localparam frac_tab_t FRAC_HALF = mk_frac_tab(4096);

endpackage

FILE: hdl/hvd_conv.sv
// Clamp, angle differences and degree to binary angle conversion (3 stages)
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hvd_conv (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                ce,
  input  logic                                in_valid,
  input  logic signed [hvd_pkg::LAT_W-1:0]    lat_a,
  input  logic signed [hvd_pkg::LON_W-1:0]    lon_a,
  input  logic signed [hvd_pkg::LAT_W-1:0]    lat_b,
  input  logic signed [hvd_pkg::LON_W-1:0]    lon_b,
  output logic                                out_valid,
  output hvd_pkg::q30_t                       ang [hvd_pkg::LANES]
);
  import hvd_pkg::*;

  logic [2:0]               vld_r;
  mag_t                     mag1_r [LANES];
  mag_t                     mag1_nxt [LANES];
  mag_t                     mag2_r [LANES];
  logic [QUO_W-1:0]         quo2_r [LANES];
  logic [QUO_W-1:0]         quo2_nxt [LANES];
  q30_t                     ang_r [LANES];
  q30_t                     ang_nxt [LANES];
  logic signed [LAT_W-1:0]  la_c, lb_c;
  logic signed [LON_W-1:0]  oa_c, ob_c;
  logic signed [LAT_W:0]    dlat;
  logic signed [LON_W:0]    dlon;
  logic [PROD_W-1:0]        prod [LANES];
  mag_t                     rem [LANES];
  logic [BAM_W-1:0]         bam [LANES];

  // lanes: 0 lat a, 1 lat b, 2 half lat difference, 3 half lon difference
  always_comb begin
    la_c = (lat_a > LAT_MAX) ? LAT_MAX : (lat_a < -LAT_MAX) ? -LAT_MAX : lat_a;
    lb_c = (lat_b > LAT_MAX) ? LAT_MAX : (lat_b < -LAT_MAX) ? -LAT_MAX : lat_b;
    oa_c = (lon_a > LON_MAX) ? LON_MAX : (lon_a < -LON_MAX) ? -LON_MAX : lon_a;
    ob_c = (lon_b > LON_MAX) ? LON_MAX : (lon_b < -LON_MAX) ? -LON_MAX : lon_b;
    dlat = (LAT_W+1)'(lb_c) - (LAT_W+1)'(la_c);
    dlon = (LON_W+1)'(ob_c) - (LON_W+1)'(oa_c);
    mag1_nxt[0] = MAG_W'(la_c[LAT_W-1] ? -la_c : la_c);
    mag1_nxt[1] = MAG_W'(lb_c[LAT_W-1] ? -lb_c : lb_c);
    mag1_nxt[2] = MAG_W'(dlat[LAT_W] ? -dlat : dlat);
    mag1_nxt[3] = MAG_W'(dlon[LON_W] ? -dlon : dlon);
  end

  // quotient by 45 through the reciprocal, exact for any 25-bit magnitude
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      prod[k]     = PROD_W'(mag1_r[k]) * PROD_W'(RECIP45);
      quo2_nxt[k] = prod[k][PROD_W-1:32];
    end
  end

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      rem[k] = mag2_r[k] - MAG_W'(quo2_r[k]) * MAG_W'(DIV_K);
      if (k < 2) begin
        bam[k] = (BAM_W'(quo2_r[k]) << FULL_SHIFT) + BAM_W'(FRAC_FULL[rem[k][5:0]]);
      end else begin
        bam[k] = (BAM_W'(quo2_r[k]) << HALF_SHIFT) + BAM_W'(FRAC_HALF[rem[k][5:0]]);
      end
    end
    // half lon difference past a quarter turn: same squared sine
    if (bam[3] > BAM_QUARTER) bam[3] = BAM_HALF - bam[3];
    for (int k = 0; k < LANES; k++) ang_nxt[k] = Q_W'(bam[k]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      mag1_r <= mag1_nxt;
      mag2_r <= mag1_r;
      quo2_r <= quo2_nxt;
      ang_r  <= ang_nxt;
    end
  end

  assign out_valid = vld_r[2];
  assign ang       = ang_r;

  `HVD_ASSERT(a_ang_range, !out_valid || (ang_r[0] <= Q30_ONE && ang_r[1] <= Q30_ONE && ang_r[2] <= Q30_ONE && ang_r[3] <= Q30_ONE), "angle beyond a quarter turn")

endmodule

FILE: hdl/hvd_cordic.sv
// Pipelined CORDIC, one micro-rotation per stage, rotation or vectoring
`timescale 1ns / 1ps
module hvd_cordic #(
  parameter int STAGES = hvd_pkg::CORDIC_STAGES_DEF,
  parameter int LANES  = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ce,
  input  logic          vec_mode,
  input  logic          in_valid,
  input  hvd_pkg::ang_t x_i [LANES],
  input  hvd_pkg::ang_t y_i [LANES],
  input  hvd_pkg::ang_t z_i [LANES],
  output logic          out_valid,
  output hvd_pkg::ang_t x_o [LANES],
  output hvd_pkg::ang_t y_o [LANES],
  output hvd_pkg::ang_t z_o [LANES]
);
  import hvd_pkg::*;

  localparam int NS = (STAGES > ATAN_LEN) ? ATAN_LEN : STAGES;

  logic [NS-1:0] vld_r;
  ang_t          x_r [NS][LANES];
  ang_t          y_r [NS][LANES];
  ang_t          z_r [NS][LANES];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    ang_t xs [LANES];
    ang_t ys [LANES];
    ang_t zs [LANES];
    if (i == 0) begin : g_first
      assign xs = x_i;
      assign ys = y_i;
      assign zs = z_i;
    end else begin : g_next
      assign xs = x_r[i-1];
      assign ys = y_r[i-1];
      assign zs = z_r[i-1];
    end
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic dir;   // 1: x -= y>>i, y += x>>i, z -= atan
      ang_t dx, dy, at;
      assign dir = vec_mode ? ys[l][ANG_W-1] : !zs[l][ANG_W-1];
      assign dx  = ys[l] >>> i;
      assign dy  = xs[l] >>> i;
      assign at  = ang_t'({2'b00, ATAN_TAB[i]});
      always_ff @(posedge clk) begin
        if (ce) begin
          x_r[i][l] <= dir ? xs[l] - dx : xs[l] + dx;
          y_r[i][l] <= dir ? ys[l] + dy : ys[l] - dy;
          z_r[i][l] <= dir ? zs[l] - at : zs[l] + at;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[NS-1];
  assign x_o       = x_r[NS-1];
  assign y_o       = y_r[NS-1];
  assign z_o       = z_r[NS-1];

endmodule

FILE: hdl/hvd_hav.sv
// Haversine sum of Q30 products, clamped to 1.0 (3 stages)
`timescale 1ns / 1ps
module hvd_hav (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ce,
  input  logic          in_valid,
  input  hvd_pkg::ang_t cos_a,
  input  hvd_pkg::ang_t cos_b,
  input  hvd_pkg::ang_t sin_lat,
  input  hvd_pkg::ang_t sin_lon,
  output logic          out_valid,
  output hvd_pkg::q30_t hav
);
  import hvd_pkg::*;

  function automatic q30_t q30_clamp(input ang_t v);
    if (v[ANG_W-1]) return '0;
    if (v > ang_t'(Q30_ONE)) return Q30_ONE;
    return v[Q_W-1:0];
  endfunction

  function automatic q30_t qmul(input q30_t a, input q30_t b);
    logic [2*Q_W-1:0] p;
    p = (2*Q_W)'(a) * (2*Q_W)'(b) + Q30_HALF;
    return p[Q_W+29:30];
  endfunction

  logic [2:0]   vld_r;
  q30_t         uu_r, vv_r, cc_r, uu2_r, pr_r, hav_r;
  logic [Q_W:0] sum;

  assign sum = (Q_W+1)'(uu2_r) + (Q_W+1)'(pr_r);

  always_ff @(posedge clk) begin
    if (ce) begin
      uu_r  <= qmul(q30_clamp(sin_lat), q30_clamp(sin_lat));
      vv_r  <= qmul(q30_clamp(sin_lon), q30_clamp(sin_lon));
      cc_r  <= qmul(q30_clamp(cos_a), q30_clamp(cos_b));
      uu2_r <= uu_r;
      pr_r  <= qmul(cc_r, vv_r);
      hav_r <= (sum > (Q_W+1)'(Q30_ONE)) ? Q30_ONE : sum[Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  assign out_valid = vld_r[2];
  assign hav       = hav_r;

endmodule

FILE: hdl/hvd_isqrt.sv
// Pipelined floor square root, one result bit per stage, with a side word
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hvd_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        ce,
  input  logic                        in_valid,
  input  logic [hvd_pkg::RAD_W-1:0]   rad_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        out_valid,
  output hvd_pkg::q30_t               root_o,
  output logic [SIDE_W-1:0]           side_o
);
  import hvd_pkg::*;

  logic [ROOT_STEPS-1:0] vld_r;
  logic [SQ_W-1:0]       rem_r  [ROOT_STEPS];
  logic [SQ_W-1:0]       root_r [ROOT_STEPS];
  logic [SIDE_W-1:0]     side_r [ROOT_STEPS];

  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_STEPS - 1 - j));
    logic [SQ_W-1:0]   rs, vs, t;
    logic [SIDE_W-1:0] ss;
    if (j == 0) begin : g_first
      assign rs = '0;
      assign vs = SQ_W'(rad_i);
      assign ss = side_i;
    end else begin : g_next
      assign rs = root_r[j-1];
      assign vs = rem_r[j-1];
      assign ss = side_r[j-1];
    end
    assign t = rs + BIT;
    always_ff @(posedge clk) begin
      if (ce) begin
        side_r[j] <= ss;
        if (vs >= t) begin
          rem_r[j]  <= vs - t;
          root_r[j] <= (rs >> 1) + BIT;
        end else begin
          rem_r[j]  <= vs;
          root_r[j] <= rs >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[ROOT_STEPS-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[ROOT_STEPS-1];
  assign root_o    = root_r[ROOT_STEPS-1][Q_W-1:0];
  assign side_o    = side_r[ROOT_STEPS-1];

  `HVD_ASSERT(a_root_range, !out_valid || root_r[ROOT_STEPS-1] <= SQ_W'(Q30_ONE), "root above 1.0")

endmodule

FILE: hdl/haversine_distance.sv
// Throughput: one word per cycle while not halted; every stage is registered and advances together.
// The pipeline halts only when the output register is held and its last stage is full.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
// Top level: haversine great-circle distance pipeline
`timescale 1ns / 1ps
`include "assert_macros.svh"
module haversine_distance #(
  parameter int CORDIC_STAGES = hvd_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [hvd_pkg::LAT_W-1:0]  in_lat_a,
  input  logic signed [hvd_pkg::LON_W-1:0]  in_lon_a,
  input  logic signed [hvd_pkg::LAT_W-1:0]  in_lat_b,
  input  logic signed [hvd_pkg::LON_W-1:0]  in_lon_b,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [hvd_pkg::DIST_W-1:0]        out_distance_km
);
  import hvd_pkg::*;

  logic               ce;
  logic               cv_valid, sc_valid, hv_valid, r1_valid, r2_valid, at_valid;
  q30_t               cv_ang [LANES];
  ang_t               sc_x_in [LANES], sc_y_in [LANES], sc_z_in [LANES];
  ang_t               sc_x [LANES], sc_y [LANES];
  q30_t               hav, h1, c2, h2;
  logic               hh_vld_r;
  logic [2*Q_W-1:0]   hh_r;
  q30_t               h_r;
  ang_t               at_x_in [1], at_y_in [1], at_z_in [1], at_z [1];
  logic               pa_vld_r;
  logic [Q_W+15:0]    pp_lo_r;
  logic [Q_W+16:0]    pp_hi_r;
  logic [Q_W-1:0]     zc;
  logic [64:0]        dsum;
  logic [24:0]        dq;
  logic               out_valid_r;
  logic [DIST_W-1:0]  out_dist_r, out_dist_nxt;

  // halt only when a finished word would have nowhere to go
  assign ce       = !(out_valid_r && !out_ready && pa_vld_r);
  assign in_ready = ce;

  hvd_conv u_conv (
    .clk, .rst_n, .ce, .in_valid,
    .lat_a(in_lat_a), .lon_a(in_lon_a), .lat_b(in_lat_b), .lon_b(in_lon_b),
    .out_valid(cv_valid), .ang(cv_ang)
  );

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      sc_x_in[k] = CORDIC_GAIN;
      sc_y_in[k] = '0;
      sc_z_in[k] = ang_t'(cv_ang[k]);
    end
  end

  hvd_cordic #(.STAGES(CORDIC_STAGES), .LANES(LANES)) u_sincos (
    .clk, .rst_n, .ce, .vec_mode(1'b0), .in_valid(cv_valid),
    .x_i(sc_x_in), .y_i(sc_y_in), .z_i(sc_z_in),
    .out_valid(sc_valid), .x_o(sc_x), .y_o(sc_y), .z_o()
  );

  hvd_hav u_hav (
    .clk, .rst_n, .ce, .in_valid(sc_valid),
    .cos_a(sc_x[0]), .cos_b(sc_x[1]), .sin_lat(sc_y[2]), .sin_lon(sc_y[3]),
    .out_valid(hv_valid), .hav
  );

  hvd_isqrt #(.SIDE_W(1)) u_root_h (
    .clk, .rst_n, .ce, .in_valid(hv_valid),
    .rad_i({hav, 30'd0}), .side_i(1'b0),
    .out_valid(r1_valid), .root_o(h1), .side_o()
  );

  always_ff @(posedge clk) begin
    if (ce) begin
      hh_r <= (2*Q_W)'(h1) * (2*Q_W)'(h1);
      h_r  <= h1;
    end
  end

  hvd_isqrt #(.SIDE_W(Q_W)) u_root_c (
    .clk, .rst_n, .ce, .in_valid(hh_vld_r),
    .rad_i(RAD_ONE - hh_r[RAD_W-1:0]), .side_i(h_r),
    .out_valid(r2_valid), .root_o(c2), .side_o(h2)
  );

  assign at_x_in[0] = ang_t'(c2);
  assign at_y_in[0] = ang_t'(h2);
  assign at_z_in[0] = '0;

  hvd_cordic #(.STAGES(CORDIC_STAGES), .LANES(1)) u_atan (
    .clk, .rst_n, .ce, .vec_mode(1'b1), .in_valid(r2_valid),
    .x_i(at_x_in), .y_i(at_y_in), .z_i(at_z_in),
    .out_valid(at_valid), .x_o(), .y_o(), .z_o(at_z)
  );

  // angle times 4*pi*R, split into two partial products
  assign zc = at_z[0][ANG_W-1] ? '0 : at_z[0][Q_W-1:0];

  always_ff @(posedge clk) begin
    if (ce) begin
      pp_lo_r <= (Q_W+16)'(zc) * (Q_W+16)'(DIST_MUL[15:0]);
      pp_hi_r <= (Q_W+17)'(zc) * (Q_W+17)'(DIST_MUL[32:16]);
    end
  end

  always_comb begin
    dsum         = (65'(pp_hi_r) << 16) + 65'(pp_lo_r) + (65'(1) << 39);
    dq           = dsum[64:40];
    out_dist_nxt = (dq > 25'(DIST_MAX)) ? DIST_MAX : dq[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hh_vld_r    <= 1'b0;
      pa_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ce) begin
        hh_vld_r <= r1_valid;
        pa_vld_r <= at_valid;
      end
      if (ce && pa_vld_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce && pa_vld_r) out_dist_r <= out_dist_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_distance_km = out_dist_r;

  `HVD_ASSERT(a_dist_range, !out_valid_r || out_dist_r <= DIST_MAX, "distance above half circumference")
  `HVD_ASSERT_NEXT(a_halt_keeps_word, !ce, out_valid_r, "halted pipeline lost its output word")
  `HVD_ASSERT_NEXT(a_out_stable, out_valid_r && !out_ready, out_valid_r && $stable(out_dist_r), "output word changed while waiting")

endmodule

FILE: test/haversine_distance_test.sv
// Self-checking testbench for the haversine great-circle distance pipeline
`timescale 1ns / 1ps
module haversine_distance_test;
  import hvd_pkg::*;

  localparam int STAGES = CORDIC_STAGES_DEF;
  localparam int LATENCY = 2 * STAGES + 71;
  localparam int N_RANDOM = 400;
  localparam longint CYCLE_LIMIT = 400000;
  localparam longint LAT_LIM = 5898240;
  localparam longint LON_LIM = 11796480;
  localparam longint QUARTER = 64'd1073741824;
  localparam longint HALF_TURN = 64'd2147483648;
  localparam longint ONE_Q30 = 64'd1073741824;

  typedef struct packed {
    logic [LAT_W-1:0] lat_a;
    logic [LON_W-1:0] lon_a;
    logic [LAT_W-1:0] lat_b;
    logic [LON_W-1:0] lon_b;
  } pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [LAT_W-1:0] in_lat_a = '0;
  logic signed [LON_W-1:0] in_lon_a = '0;
  logic signed [LAT_W-1:0] in_lat_b = '0;
  logic signed [LON_W-1:0] in_lon_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DIST_W-1:0] out_distance_km;

  pair_t pending_pairs[$];
  logic [DIST_W-1:0] expected_dist[$];
  int mismatches = 0;
  int results_seen = 0;
  int words_sent = 0;
  longint cycles = 0;
  bit stim_done = 1'b0;
  bit hold_sink = 1'b0;
  int send_gap = 0;
  int sink_gap = 0;
  bit accepted_last = 1'b0;
  bit pause_send = 1'b0;

  haversine_distance #(.CORDIC_STAGES(STAGES)) DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint clamp_to(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint asr64(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint q30_sat(longint v);
    if (v < 0) return 0;
    if (v > ONE_Q30) return ONE_Q30;
    return v;
  endfunction

  function automatic longint deg_to_bam(longint mag, longint scale);
    return (mag * scale + 180) / 360;
  endfunction

  // rotation mode: returns {cos, sin} in Q30
  function automatic void rotate(input longint ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = 652032874;
    y = 0;
    z = ang;
    for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
      dx = asr64(y, i);
      dy = asr64(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end
    end
    c = q30_sat(x);
    s = q30_sat(y);
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
      dx = asr64(y, i);
      dy = asr64(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end
    end
    return z;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
    return (a * b + 64'd536870912) >> 30;
  endfunction

  function automatic logic [DIST_W-1:0] great_circle_km(pair_t p);
    longint la, oa, lb, ob, hlat, hlon, ca, cb, u, v, junk, z;
    longint unsigned hav, h, c2, km;
    logic [127:0] wide;
    la = clamp_to(longint'($signed(p.lat_a)), LAT_LIM);
    oa = clamp_to(longint'($signed(p.lon_a)), LON_LIM);
    lb = clamp_to(longint'($signed(p.lat_b)), LAT_LIM);
    ob = clamp_to(longint'($signed(p.lon_b)), LON_LIM);
    hlat = deg_to_bam((lb > la) ? lb - la : la - lb, 32768);
    hlon = deg_to_bam((ob > oa) ? ob - oa : oa - ob, 32768);
    if (hlon > QUARTER) hlon = HALF_TURN - hlon;
    rotate(deg_to_bam((la < 0) ? -la : la, 65536), ca, junk);
    rotate(deg_to_bam((lb < 0) ? -lb : lb, 65536), cb, junk);
    rotate(hlat, junk, u);
    rotate(hlon, junk, v);
    hav = q30_mul(u, u) + q30_mul(q30_mul(ca, cb), q30_mul(v, v));
    if (hav > ONE_Q30) hav = ONE_Q30;
    h = floor_sqrt(hav << 30);
    if (h > ONE_Q30) h = ONE_Q30;
    c2 = floor_sqrt((ONE_Q30 << 30) - h * h);
    z = vector_angle(longint'(c2), longint'(h));
    if (z < 0) z = 0;
    wide = 128'(z) * 128'(64'd5246834913) + (128'd1 << 39);
    km = 64'(wide >> 40);
    if (km > 64'd5124096) km = 64'd5124096;
    return km[DIST_W-1:0];
  endfunction

  function automatic logic [LAT_W-1:0] rand_lat();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return LAT_W'($urandom);
    return LAT_W'($signed($urandom_range(0, 2 * 5898240)) - 5898240);
  endfunction

  function automatic logic [LON_W-1:0] rand_lon();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return LON_W'($urandom);
    return LON_W'($signed($urandom_range(0, 2 * 11796480)) - 11796480);
  endfunction

  task automatic add_pair(longint a, longint b, longint c, longint d);
    pair_t p;
    p.lat_a = LAT_W'(a);
    p.lon_a = LON_W'(b);
    p.lat_b = LAT_W'(c);
    p.lon_b = LON_W'(d);
    pending_pairs.push_back(p);
  endtask

  // driver: a word stays on the port until accepted
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || accepted_last) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_pairs.size() > 0 && !(pause_send)) begin
          pair_t p;
          p = pending_pairs.pop_front();
          in_lat_a <= p.lat_a;
          in_lon_a <= p.lon_a;
          in_lat_b <= p.lat_b;
          in_lon_b <= p.lon_b;
          in_valid <= 1'b1;
          send_gap <= rand_gap();
        end else in_valid <= 1'b0;
      end
    end
  end

  // monitor: predict on input acceptance, check on output acceptance
  always @(posedge clk) begin
    cycles <= cycles + 1;
    accepted_last <= in_valid && in_ready && rst_n;
    if (rst_n && in_valid && in_ready) begin
      pair_t p;
      p = {in_lat_a, in_lon_a, in_lat_b, in_lon_b};
      expected_dist.push_back(great_circle_km(p));
      words_sent <= words_sent + 1;
    end
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (expected_dist.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result word %0d", out_distance_km);
      end else begin
        logic [DIST_W-1:0] want;
        want = expected_dist.pop_front();
        if (want !== out_distance_km) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("distance mismatch: expected %0d got %0d", want, out_distance_km);
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (hold_sink) out_ready <= 1'b0;
    else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) sink_gap <= rand_gap();
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int hold_cycles;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // extremes, identity, antipodes, wrap and clamping
    add_pair(0, 0, 0, 0);
    add_pair(LAT_LIM, 0, -LAT_LIM, 0);
    add_pair(0, -LON_LIM, 0, LON_LIM);
    add_pair(0, 0, 0, LON_LIM);
    add_pair(LAT_LIM, LON_LIM, LAT_LIM, -LON_LIM);
    add_pair(-LAT_LIM, 123456, -LAT_LIM, -654321);
    add_pair(8388607, 16777215, -8388608, -16777216);
    add_pair(-8388608, -16777216, 8388607, 16777215);
    add_pair(LAT_LIM + 1, LON_LIM + 1, -LAT_LIM - 1, -LON_LIM - 1);
    add_pair(0, 0, 0, 1);
    add_pair(1, 0, 0, 0);
    add_pair(0, -5898240, 0, 5898240);
    add_pair(0, -5898241, 0, 5898240);
    add_pair(0, -8000000, 0, 8000000);
    add_pair(2600000, -5000000, -2600000, 6796480);
    add_pair(-1, -1, -1, -1);
    add_pair(2655000, -4840000, 2230000, -7720000);
    add_pair(0, 11796480, 0, -11796480);
    add_pair(5898239, 0, 5898240, 11796480);
    add_pair(-5898240, 0, 5898240, 0);
    wait (pending_pairs.size() == 0 && expected_dist.size() == 0);
    // receiver holds off while the sender keeps feeding, so the pipe fills
    hold_sink = 1'b1;
    for (int i = 0; i < N_RANDOM / 2; i++)
      add_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon());
    hold_cycles = 0;
    while (hold_cycles < 3 * LATENCY) begin
      @(posedge clk);
      hold_cycles++;
    end
    @(negedge clk);
    hold_sink = 1'b0;
    wait (pending_pairs.size() == 0);
    // sender pauses until everything drains
    pause_send = 1'b1;
    for (int i = 0; i < N_RANDOM / 2; i++)
      add_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon());
    wait (expected_dist.size() == 0);
    @(negedge clk);
    pause_send = 1'b0;
    wait (pending_pairs.size() == 0);
    stim_done = 1'b1;
    wait (!in_valid);
    wait (expected_dist.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d point pairs (corners, clamped and wrapped fields, random),", words_sent);
    $display("checked %0d distances with stalls on both sides.", results_seen);
    if (mismatches == 0 && expected_dist.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
